/* hw/rtl/lru_pkg.sv */
// Shared constants for the LRU page replacement block.
// No dependencies; imported by the top level.
package lru_pkg;
   localparam int FRAMES_DEF     = 8;
   localparam int PAGE_BITS_DEF  = 8;
   localparam int STAMP_BITS_DEF = 16;
   localparam int FAULT_W        = 16;
   localparam int INDEX_OUT_W    = 3;
   localparam int CSR_W          = 4;
   localparam logic [CSR_W-1:0] CSR_RESET = 4'd8;
   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
endpackage

/* hw/rtl/lru_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/lru_page_replacement.sv */
// LRU page replacement engine: top level.
// Depends on lru_pkg and lru_ram.
//
// Usage:
//  - Drive req_page, req_start_run and req_last_reference with start high; the
//    transaction is taken at a rising edge where start is high and busy is low.
//  - req_start_run empties all frames and clears the use clock and fault count
//    before the reference is served.
//  - One result transaction follows each request: rsp_valid is high for exactly
//    one cycle with rsp_hit, rsp_frame_index, rsp_fault_count and rsp_run_done.
//    The receiver cannot stall; the result must be taken in that cycle.
//  - The page/stamp RAM is scanned serially, one frame read per cycle, over the
//    active frames (frames_in_use clamped to 1..FRAMES), followed by a drain
//    state and a write-back state; the result is registered in the write-back
//    state, and a new request can be taken in the result cycle.
//  - csr_we with csr_wdata writes frames_in_use; write only while busy is low.
//  - Reset (synchronous, active high) empties all frames, clears the counters
//    and sets frames_in_use to 8. Page and stamp RAM contents need no clearing:
//    they are read only behind a valid bit.
module lru_page_replacement #(
   parameter int FRAMES     = lru_pkg::FRAMES_DEF,
   parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
   parameter int STAMP_BITS = lru_pkg::STAMP_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [PAGE_BITS-1:0]            req_page,
   input  logic                            req_start_run,
   input  logic                            req_last_reference,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [lru_pkg::INDEX_OUT_W-1:0] rsp_frame_index,
   output logic [lru_pkg::FAULT_W-1:0]     rsp_fault_count,
   output logic                            rsp_run_done,
   input  logic                            csr_we,
   input  logic [lru_pkg::CSR_W-1:0]       csr_wdata
);
   import lru_pkg::*;

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ENTRY_W = PAGE_BITS + STAMP_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CSR_W-1:0]      csr_ff, csr_in;
   logic [FRAMES-1:0]     valid_ff, valid_in;
   logic [STAMP_BITS-1:0] clock_ff, clock_in;
   logic [FAULT_W-1:0]    faults_ff, faults_in;
   logic [IDX_W-1:0]      nlast_ff, nlast_in;
   logic [IDX_W-1:0]      issue_ff, issue_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                  hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic                  empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]      empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]      min_idx_ff, min_idx_in;
   logic [STAMP_BITS-1:0] min_stamp_ff, min_stamp_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [INDEX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [FAULT_W-1:0]    rsp_faults_ff, rsp_faults_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  accept;
   int                    active;
   logic [ENTRY_W-1:0]    rd_data;
   logic [PAGE_BITS-1:0]  rd_page;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic                  rd_en;
   logic                  wr_en;
   logic [IDX_W-1:0]      chosen;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign rd_page  = rd_data[STAMP_BITS +: PAGE_BITS];
   assign rd_stamp = rd_data[STAMP_BITS-1:0];
   assign rd_en    = (state_ff == ST_SCAN);
   assign wr_en    = (state_ff == ST_WRITE);

   always_comb begin
      if (csr_ff == '0) begin
         active = 1;
      end else if (int'(csr_ff) > FRAMES) begin
         active = FRAMES;
      end else begin
         active = int'(csr_ff);
      end
   end

   always_comb begin
      priority if (hit_found_ff) begin
         chosen = hit_idx_ff;
      end else if (empty_found_ff) begin
         chosen = empty_idx_ff;
      end else begin
         chosen = min_idx_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      csr_in         = csr_we ? csr_wdata : csr_ff;
      valid_in       = valid_ff;
      clock_in       = clock_ff;
      faults_in      = faults_ff;
      nlast_in       = nlast_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = issue_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      min_idx_in     = min_idx_ff;
      min_stamp_in   = min_stamp_ff;
      page_in        = page_ff;
      last_in        = last_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_faults_in  = rsp_faults_ff;
      rsp_done_in    = rsp_done_ff;

      // fold in the entry read last cycle
      if (chk_vld_ff) begin
         if (valid_ff[chk_idx_ff] && (rd_page == page_ff) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = chk_idx_ff;
         end
         if (!valid_ff[chk_idx_ff] && !empty_found_ff) begin
            empty_found_in = 1'b1;
            empty_idx_in   = chk_idx_ff;
         end
         if ((chk_idx_ff == '0) || (rd_stamp < min_stamp_ff)) begin
            min_idx_in   = chk_idx_ff;
            min_stamp_in = rd_stamp;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               page_in        = req_page;
               last_in        = req_last_reference;
               nlast_in       = IDX_W'(active - 1);
               issue_in       = '0;
               hit_found_in   = 1'b0;
               empty_found_in = 1'b0;
               state_in       = ST_SCAN;
               if (req_start_run) begin
                  valid_in  = '0;
                  clock_in  = '0;
                  faults_in = '0;
               end
            end
         end
         ST_SCAN: begin
            chk_vld_in = 1'b1;
            chk_idx_in = issue_ff;
            issue_in   = issue_ff + 1'b1;
            if (issue_ff == nlast_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            valid_in[chosen] = 1'b1;
            if (!hit_found_ff && (faults_ff != FAULT_MAX)) begin
               faults_in = faults_ff + 1'b1;
            end
            clock_in      = clock_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_hit_in    = hit_found_ff;
            rsp_index_in  = INDEX_OUT_W'(chosen);
            rsp_faults_in = faults_in;
            rsp_done_in   = last_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_RESET;
         valid_ff     <= '0;
         clock_ff     <= '0;
         faults_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         valid_ff     <= valid_in;
         clock_ff     <= clock_in;
         faults_ff    <= faults_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nlast_ff       <= nlast_in;
      issue_ff       <= issue_in;
      chk_idx_ff     <= chk_idx_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      min_idx_ff     <= min_idx_in;
      min_stamp_ff   <= min_stamp_in;
      page_ff        <= page_in;
      last_ff        <= last_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_faults_ff  <= rsp_faults_in;
      rsp_done_ff    <= rsp_done_in;
   end

   lru_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(FRAMES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(chosen),
      .wr_data({page_ff, clock_ff}),
      .rd_en  (rd_en),
      .rd_addr(issue_ff),
      .rd_data(rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_index = rsp_index_ff;
   assign rsp_fault_count = rsp_faults_ff;
   assign rsp_run_done    = rsp_done_ff;

   a_write_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> rsp_valid_ff)
      else $error("write-back not followed by a result");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while busy");

   a_hit_keeps_faults: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WRITE) && hit_found_ff) |=> (faults_ff == $past(faults_ff)))
      else $error("fault count changed on a hit");

   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (chk_idx_ff <= nlast_ff))
      else $error("scan ran past the active frames");
endmodule
